/* hdl/bsfl_pkg.sv */
// Shared types, codes and sizes for the bounded slot free list.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bsfl_pkg;

  localparam int SLOT_CAP  = 256;
  localparam int ID_W      = $clog2(SLOT_CAP);
  localparam int CNT_W     = $clog2(SLOT_CAP + 1);
  localparam int KIND_W    = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_INIT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESIZE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SHRINK  = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SLOTS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALTED     = 2'd2;

  localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = 9'd256;
  localparam logic [CNT_W-1:0] BASE_SLOTS_RST = 9'd16;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t base;
    cnt_t eff_lim;
    logic halted;
  } cfg_t;

  typedef struct packed {
    logic we;
    id_t  waddr;
    logic wbit;
    logic re;
    id_t  raddr;
  } pres_ctl_t;

endpackage

/* hdl/bsfl_cfg.sv */
// Configuration registers and effective slot limit.
// Depends on bsfl_pkg.
`timescale 1ns / 1ps

module bsfl_cfg import bsfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  cnt_t                 cfg_wdata,
  input  logic                 wb_en,
  input  cnt_t                 wb_val,
  output cfg_t                 cfg
);

  cnt_t slot_limit_r;
  cnt_t base_r;
  logic halted_r;
  cnt_t lim0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= SLOT_LIMIT_RST;
      base_r       <= BASE_SLOTS_RST;
      halted_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT_LIMIT: slot_limit_r <= cfg_wdata;
        REG_BASE_SLOTS: begin
          if (cfg_wdata != '0) base_r <= cfg_wdata;
        end
        REG_HALTED:     halted_r <= cfg_wdata[0];
        default: ;
      endcase
    end else if (wb_en) begin
      base_r <= wb_val;
    end
  end

  // zero limit means the full table
  assign lim0 = (slot_limit_r == '0) ? CNT_W'(SLOT_CAP) : slot_limit_r;

  always_comb begin
    cfg.base    = base_r;
    cfg.halted  = halted_r;
    cfg.eff_lim = (lim0 > CNT_W'(SLOT_CAP)) ? CNT_W'(SLOT_CAP) : lim0;
  end

endmodule

/* hdl/bsfl_presence.sv */
// Presence flags over slot ids: a one-bit memory with a registered read port.
// Depends on bsfl_pkg.
`timescale 1ns / 1ps

module bsfl_presence import bsfl_pkg::*; (
  input  logic      clk,
  input  pres_ctl_t ctl,
  output logic      rd_bit
);

  logic pres_mem [SLOT_CAP];
  logic rd_bit_r;

  always_ff @(posedge clk) begin
    if (ctl.we) pres_mem[ctl.waddr] <= ctl.wbit;
    if (ctl.re) rd_bit_r <= pres_mem[ctl.raddr];
  end

  assign rd_bit = rd_bit_r;

endmodule

/* hdl/bounded_slot_free_list_top.sv */
// Bounded slot free list: top level with the queue memory and sequencer.
// Depends on bsfl_pkg, bsfl_cfg and bsfl_presence.
`timescale 1ns / 1ps

// A ring of 256 free slot ids in one memory with a registered read port.
// Acquire, release, failed operations and unknown kinds go straight to the
// response. Init makes one memory write per id. A growing resize writes the
// ids from the old provisioned count up to the new count. A narrowing resize
// walks the queue once. A shrink clears the presence flags for the ids from
// base up to provisioned, marks the queued ones, scans them and then, if all
// of them are queued, compacts the queue. No clearing pass follows reset.
// A finished result waits in the output register while the next beat enters.

module bounded_slot_free_list_top import bsfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  id_t                  in_slot_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ok,
  output id_t                  out_granted_id,
  output cnt_t                 out_free_count,
  output cnt_t                 out_allowed_count,
  output cnt_t                 out_peak_used,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  cnt_t                 cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_GROW  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_FILT  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;
  localparam logic [2:0] ST_CLR   = 3'd6;
  localparam logic [2:0] ST_SCAN  = 3'd7;

  cfg_t      cfg;
  pres_ctl_t pres_ctl;
  logic      pres_q;
  logic      wb_en;
  cnt_t      wb_val;

  logic [2:0] state_r, state_nxt;
  logic       ready_r, ready_nxt;
  id_t        head_r, head_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       allowed_r, allowed_nxt;
  cnt_t       prov_r, prov_nxt;
  cnt_t       peak_r, peak_nxt;
  logic       vld_r, vld_nxt;
  logic       out_valid_r, out_valid_nxt;

  cnt_t idx_r, idx_nxt;
  cnt_t bound_r, bound_nxt;
  cnt_t keep_r, keep_nxt;
  logic shrink_op_r, shrink_op_nxt;
  logic ok_r, ok_nxt;
  logic acq_r, acq_nxt;

  logic o_ok_r, o_ok_nxt;
  id_t  o_gid_r, o_gid_nxt;
  cnt_t o_free_r, o_free_nxt;
  cnt_t o_allowed_r, o_allowed_nxt;
  cnt_t o_peak_r, o_peak_nxt;

  id_t mem [SLOT_CAP];
  id_t mem_rdata_r;
  logic mem_we, mem_re;
  id_t  mem_waddr, mem_raddr, mem_wdata;

  cnt_t n_init, desired, used, cnt_dec;
  logic issue, done, scan_go, scan_done;

  bsfl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .wb_en     (wb_en),
    .wb_val    (wb_val),
    .cfg       (cfg)
  );

  bsfl_presence u_presence (
    .clk    (clk),
    .ctl    (pres_ctl),
    .rd_bit (pres_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    n_init = cfg.base;
    if (n_init < CNT_W'(1)) n_init = CNT_W'(1);
    if (n_init > cfg.eff_lim) n_init = cfg.eff_lim;
    desired   = (cfg.base < cfg.eff_lim) ? cfg.base : cfg.eff_lim;
    cnt_dec   = count_r - 1'b1;
    used      = (allowed_r > cnt_dec) ? allowed_r - cnt_dec : '0;
    issue     = (idx_r < count_r);
    done      = !issue && !vld_r;
    scan_go   = (idx_r < prov_r);
    scan_done = !scan_go && !vld_r;
  end

  always_comb begin
    state_nxt      = state_r;
    ready_nxt      = ready_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    allowed_nxt    = allowed_r;
    prov_nxt       = prov_r;
    peak_nxt       = peak_r;
    vld_nxt        = 1'b0;
    idx_nxt        = idx_r;
    bound_nxt      = bound_r;
    keep_nxt       = keep_r;
    shrink_op_nxt  = shrink_op_r;
    ok_nxt         = ok_r;
    acq_nxt        = acq_r;
    o_ok_nxt       = o_ok_r;
    o_gid_nxt      = o_gid_r;
    o_free_nxt     = o_free_r;
    o_allowed_nxt  = o_allowed_r;
    o_peak_nxt     = o_peak_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_waddr      = head_r + count_r[ID_W-1:0];
    mem_wdata      = in_slot_id;
    mem_re         = 1'b0;
    mem_raddr      = head_r + idx_r[ID_W-1:0];
    wb_en          = 1'b0;
    wb_val         = n_init;
    pres_ctl.we    = 1'b0;
    pres_ctl.waddr = mem_rdata_r;
    pres_ctl.wbit  = 1'b1;
    pres_ctl.re    = 1'b0;
    pres_ctl.raddr = idx_r[ID_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acq_nxt   = 1'b0;
          state_nxt = ST_RESP;
          case (in_kind)
            KIND_INIT: begin
              ok_nxt = 1'b1;
              if (!ready_r) begin
                wb_en     = 1'b1;
                head_nxt  = '0;
                count_nxt = '0;
                bound_nxt = n_init;
                idx_nxt   = '0;
                state_nxt = ST_FILL;
              end
            end
            KIND_ACQUIRE: begin
              if (cfg.halted || count_r == '0) begin
                ok_nxt = 1'b0;
              end else begin
                ok_nxt    = 1'b1;
                acq_nxt   = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = head_r;
                head_nxt  = head_r + 1'b1;
                count_nxt = cnt_dec;
                if (used > peak_r) peak_nxt = used;
              end
            end
            KIND_RELEASE: begin
              if ({1'b0, in_slot_id} < allowed_r && count_r < CNT_W'(SLOT_CAP)) begin
                ok_nxt    = 1'b1;
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                ok_nxt = 1'b0;
              end
            end
            KIND_RESIZE: begin
              if (!ready_r) begin
                ok_nxt = 1'b0;
              end else if (desired <= allowed_r) begin
                allowed_nxt   = desired;
                bound_nxt     = desired;
                shrink_op_nxt = 1'b0;
                idx_nxt       = '0;
                keep_nxt      = '0;
                state_nxt     = ST_FILT;
              end else begin
                idx_nxt   = prov_r;
                bound_nxt = desired;
                state_nxt = ST_GROW;
              end
            end
            KIND_SHRINK: begin
              ok_nxt = 1'b1;
              if (ready_r && cfg.base < prov_r) begin
                idx_nxt   = cfg.base;
                state_nxt = ST_CLR;
              end
            end
            default: ok_nxt = 1'b0;
          endcase
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[ID_W-1:0];
        mem_wdata = idx_r[ID_W-1:0];
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == bound_r - 1'b1) begin
          count_nxt   = bound_r;
          prov_nxt    = bound_r;
          allowed_nxt = bound_r;
          ready_nxt   = 1'b1;
          state_nxt   = ST_RESP;
        end
      end

      ST_GROW: begin
        if (idx_r < bound_r) begin
          if (count_r < CNT_W'(SLOT_CAP)) begin
            mem_we    = 1'b1;
            mem_wdata = idx_r[ID_W-1:0];
            count_nxt = count_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          prov_nxt    = bound_r;
          allowed_nxt = bound_r;
          ok_nxt      = 1'b1;
          state_nxt   = ST_RESP;
        end
      end

      // clear the flags for ids in [base, provisioned)
      ST_CLR: begin
        pres_ctl.we    = 1'b1;
        pres_ctl.waddr = idx_r[ID_W-1:0];
        pres_ctl.wbit  = 1'b0;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == prov_r - 1'b1) begin
          idx_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end

      // mark every queued id in [base, provisioned)
      ST_CHECK: begin
        mem_re  = issue;
        vld_nxt = issue;
        if (issue) idx_nxt = idx_r + 1'b1;
        if (vld_r && {1'b0, mem_rdata_r} >= cfg.base && {1'b0, mem_rdata_r} < prov_r) begin
          pres_ctl.we = 1'b1;
        end
        if (done) begin
          idx_nxt   = cfg.base;
          state_nxt = ST_SCAN;
        end
      end

      // every flag in [base, provisioned) must be set
      ST_SCAN: begin
        pres_ctl.re = scan_go;
        vld_nxt     = scan_go;
        if (scan_go) idx_nxt = idx_r + 1'b1;
        if (vld_r && !pres_q) ok_nxt = 1'b0;
        if (scan_done) begin
          if (ok_r) begin
            idx_nxt       = '0;
            keep_nxt      = '0;
            bound_nxt     = cfg.base;
            shrink_op_nxt = 1'b1;
            state_nxt     = ST_FILT;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_FILT: begin
        // compaction stays behind the read pointer, so the ring is safe
        mem_re  = issue;
        vld_nxt = issue;
        if (issue) idx_nxt = idx_r + 1'b1;
        if (vld_r && {1'b0, mem_rdata_r} < bound_r) begin
          mem_we    = 1'b1;
          mem_waddr = head_r + keep_r[ID_W-1:0];
          mem_wdata = mem_rdata_r;
          keep_nxt  = keep_r + 1'b1;
        end
        if (done) begin
          count_nxt = keep_r;
          if (shrink_op_r) begin
            prov_nxt    = bound_r;
            allowed_nxt = bound_r;
          end
          ok_nxt    = 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          o_ok_nxt      = ok_r;
          o_gid_nxt     = acq_r ? mem_rdata_r : '0;
          o_free_nxt    = count_r;
          o_allowed_nxt = allowed_r;
          o_peak_nxt    = peak_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      allowed_r   <= '0;
      prov_r      <= '0;
      peak_r      <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      allowed_r   <= allowed_nxt;
      prov_r      <= prov_nxt;
      peak_r      <= peak_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    bound_r     <= bound_nxt;
    keep_r      <= keep_nxt;
    shrink_op_r <= shrink_op_nxt;
    ok_r        <= ok_nxt;
    acq_r       <= acq_nxt;
    o_ok_r      <= o_ok_nxt;
    o_gid_r     <= o_gid_nxt;
    o_free_r    <= o_free_nxt;
    o_allowed_r <= o_allowed_nxt;
    o_peak_r    <= o_peak_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = o_ok_r;
  assign out_granted_id    = o_gid_r;
  assign out_free_count    = o_free_r;
  assign out_allowed_count = o_allowed_r;
  assign out_peak_used     = o_peak_r;

endmodule

/* bench/bsfl_slot_monitor.sv */
// Free list monitor: watches the beat, result and register ports, keeps its own
// copy of the slot queue and compares every result beat field by field.
// Depends on bsfl_pkg.
`timescale 1ns / 1ps

module bsfl_slot_monitor import bsfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  id_t                  in_slot_id,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_ok,
  input  id_t                  out_granted_id,
  input  cnt_t                 out_free_count,
  input  cnt_t                 out_allowed_count,
  input  cnt_t                 out_peak_used,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  cnt_t                 cfg_wdata,
  output int                   fail_count,
  output int                   answers_owed
);

  typedef struct {
    logic ok;
    id_t  gid;
    cnt_t free_n;
    cnt_t allow_n;
    cnt_t peak_n;
  } slot_answer_t;

  slot_answer_t answers_due[$];

  id_t         ring [SLOT_CAP];
  int unsigned ring_head, ring_count, allow_cnt, prov_cnt, peak_cnt;
  bit          set_up;
  int unsigned limit_reg, base_reg;
  bit          halt_reg;

  initial begin
    fail_count   = 0;
    answers_owed = 0;
  end

  // zero means the full 256, anything wider saturates
  function automatic int unsigned clamp_limit();
    int unsigned l;
    l = (limit_reg == 0) ? 256 : limit_reg;
    return (l > SLOT_CAP) ? SLOT_CAP : l;
  endfunction

  function automatic bit append_id(int unsigned id);
    if (ring_count >= SLOT_CAP) return 1'b0;
    ring[(ring_head + ring_count) % SLOT_CAP] = id_t'(id);
    ring_count++;
    return 1'b1;
  endfunction

  // queue order kept, head restarts at zero
  function automatic void keep_below(int unsigned bound);
    id_t         kept [SLOT_CAP];
    int unsigned n, i;
    n = 0;
    for (i = 0; i < ring_count; i++) begin
      if (ring[(ring_head + i) % SLOT_CAP] < bound) begin
        kept[n] = ring[(ring_head + i) % SLOT_CAP];
        n++;
      end
    end
    for (i = 0; i < n; i++) ring[i] = kept[i];
    ring_head  = 0;
    ring_count = n;
  endfunction

  function automatic slot_answer_t apply_slot_op(logic [KIND_W-1:0] kind, id_t sid);
    slot_answer_t a;
    int unsigned  n, i, used, want;
    bit           seen [SLOT_CAP];
    a.ok  = 1'b0;
    a.gid = '0;
    case (kind)
      KIND_INIT: begin
        if (!set_up) begin
          n = base_reg;
          if (n < 1) n = 1;
          if (n > clamp_limit()) n = clamp_limit();
          base_reg   = n;
          ring_head  = 0;
          ring_count = 0;
          for (i = 0; i < n; i++) void'(append_id(i));
          prov_cnt  = n;
          allow_cnt = n;
          set_up    = 1'b1;
        end
        a.ok = 1'b1;
      end
      KIND_ACQUIRE: begin
        if (!halt_reg && ring_count != 0) begin
          a.ok       = 1'b1;
          a.gid      = ring[ring_head];
          ring_head  = (ring_head + 1) % SLOT_CAP;
          ring_count--;
          used = (allow_cnt > ring_count) ? allow_cnt - ring_count : 0;
          if (used > peak_cnt) peak_cnt = used;
        end
      end
      KIND_RELEASE: begin
        if (sid < allow_cnt) a.ok = append_id(sid);
      end
      KIND_RESIZE: begin
        if (set_up) begin
          want = (base_reg < clamp_limit()) ? base_reg : clamp_limit();
          if (want <= allow_cnt) begin
            allow_cnt = want;
            keep_below(want);
          end else begin
            // appends past a full queue are lost
            for (i = prov_cnt; i < want; i++) void'(append_id(i));
            prov_cnt  = want;
            allow_cnt = want;
          end
          a.ok = 1'b1;
        end
      end
      KIND_SHRINK: begin
        a.ok = 1'b1;
        if (set_up && base_reg < prov_cnt) begin
          for (i = 0; i < SLOT_CAP; i++) seen[i] = 1'b0;
          for (i = 0; i < ring_count; i++) seen[ring[(ring_head + i) % SLOT_CAP]] = 1'b1;
          for (i = base_reg; i < prov_cnt && i < SLOT_CAP; i++)
            if (!seen[i]) a.ok = 1'b0;
          if (a.ok) begin
            keep_below(base_reg);
            prov_cnt  = base_reg;
            allow_cnt = base_reg;
          end
        end
      end
      default: begin
        a.ok = 1'b0;
      end
    endcase
    a.free_n  = cnt_t'(ring_count);
    a.allow_n = cnt_t'(allow_cnt);
    a.peak_n  = cnt_t'(peak_cnt);
    return a;
  endfunction

  task automatic check_field(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    slot_answer_t head_ans;
    if (!rst_n) begin
      limit_reg  = SLOT_LIMIT_RST;
      base_reg   = BASE_SLOTS_RST;
      halt_reg   = 1'b0;
      ring_head  = 0;
      ring_count = 0;
      allow_cnt  = 0;
      prov_cnt   = 0;
      peak_cnt   = 0;
      set_up     = 1'b0;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOT_LIMIT: begin
            limit_reg = cfg_wdata;
          end
          REG_BASE_SLOTS: begin
            if (cfg_wdata != 0) base_reg = cfg_wdata;
          end
          REG_HALTED: begin
            halt_reg = cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        answers_due.insert(answers_due.size(), apply_slot_op(in_kind, in_slot_id));
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing outstanding, got ok %0b id %0d", $time,
                   out_ok, out_granted_id);
        end else begin
          head_ans = answers_due[0];
          answers_due.delete(0);
          check_field("ok", head_ans.ok, out_ok);
          check_field("granted_id", head_ans.gid, out_granted_id);
          check_field("free_count", head_ans.free_n, out_free_count);
          check_field("allowed_count", head_ans.allow_n, out_allowed_count);
          check_field("peak_used", head_ans.peak_n, out_peak_used);
        end
      end
    end
    answers_owed = answers_due.size();
  end

endmodule

/* bench/tb_bounded_slot_free_list_top.sv */
// Bench top for the slot free list: clock, reset, beat and register stimulus.
// Depends on bsfl_pkg, bounded_slot_free_list_top and bsfl_slot_monitor.
`timescale 1ns / 1ps

module tb_bounded_slot_free_list_top;
  import bsfl_pkg::*;

  localparam int RANDOM_ITEMS   = 1350;
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int KIND_FIRST_BAD = KIND_SHRINK + 1;
  localparam int KIND_LAST      = (1 << KIND_W) - 1;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [KIND_W-1:0]    in_kind    = KIND_INIT;
  id_t                  in_slot_id = '0;
  logic                 out_ready  = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index  = REG_SLOT_LIMIT;
  cnt_t                 cfg_wdata  = '0;
  logic                 in_ready, out_valid, out_ok;
  id_t                  out_granted_id;
  cnt_t                 out_free_count, out_allowed_count, out_peak_used;

  int          fail_count, answers_owed;
  int          idle_cycles = 0;
  int          items_sent  = 0;
  bit          no_gaps     = 1'b0;
  int unsigned id_span     = BASE_SLOTS_RST;

  bounded_slot_free_list_top dut (.*);

  bsfl_slot_monitor u_monitor (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_op(logic [KIND_W-1:0] kind, id_t sid);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_slot_id <= sid;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [REG_IDX_W-1:0] idx, cnt_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BASE_SLOTS && val != 0) id_span = (val > SLOT_CAP) ? SLOT_CAP : val;
  endtask

  function automatic id_t release_id();
    case ($urandom_range(0, 15))
      0: begin
        return id_t'($urandom_range(0, 255));
      end
      1: begin
        return '1;
      end
      default: begin
        return id_t'($urandom_range(0, id_span - 1));
      end
    endcase
  endfunction

  task automatic mixed_traffic(int unsigned len);
    int unsigned r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_op(KIND_ACQUIRE, id_t'($urandom));
      else if (r < 85) send_op(KIND_RELEASE, release_id());
      else if (r < 89) send_op(KIND_RESIZE, id_t'($urandom));
      else if (r < 93) send_op(KIND_SHRINK, id_t'($urandom));
      else if (r < 95) send_op(KIND_INIT, id_t'($urandom));
      else send_op(KIND_W'($urandom_range(KIND_FIRST_BAD, KIND_LAST)), id_t'($urandom));
    end
  endtask

  // mostly small bases; full size and out of range values now and then
  task automatic shuffle_config();
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0: begin
          set_reg(REG_BASE_SLOTS, '0);
        end
        1: begin
          set_reg(REG_BASE_SLOTS, cnt_t'(1));
        end
        2: begin
          set_reg(REG_BASE_SLOTS, cnt_t'(SLOT_CAP));
        end
        3: begin
          set_reg(REG_BASE_SLOTS, cnt_t'($urandom));
        end
        default: begin
          set_reg(REG_BASE_SLOTS, cnt_t'($urandom_range(2, 40)));
        end
      endcase
    end
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 5))
        0: begin
          set_reg(REG_SLOT_LIMIT, '0);
        end
        1: begin
          set_reg(REG_SLOT_LIMIT, cnt_t'(1));
        end
        2: begin
          set_reg(REG_SLOT_LIMIT, '1);
        end
        3: begin
          set_reg(REG_SLOT_LIMIT, cnt_t'($urandom));
        end
        4: begin
          set_reg(REG_SLOT_LIMIT, cnt_t'($urandom_range(2, 64)));
        end
        default: begin
          set_reg(REG_SLOT_LIMIT, cnt_t'(SLOT_CAP));
        end
      endcase
    end
    set_reg(REG_HALTED, cnt_t'($urandom_range(0, 5) == 0));
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before init
    send_op(KIND_ACQUIRE, '0);
    send_op(KIND_RELEASE, '0);
    send_op(KIND_RESIZE, '0);
    send_op(KIND_SHRINK, '0);
    for (int k = KIND_FIRST_BAD; k <= KIND_LAST; k++) send_op(KIND_W'(k), '1);

    // init clamped by the limit; zero base write ignored
    settle();
    set_reg(REG_SLOT_LIMIT, cnt_t'(4));
    set_reg(REG_BASE_SLOTS, '0);
    send_op(KIND_INIT, '0);
    send_op(KIND_INIT, '0);
    send_op(KIND_ACQUIRE, '0);
    send_op(KIND_ACQUIRE, '0);
    send_op(KIND_RELEASE, '1);
    send_op(KIND_RELEASE, id_t'(1));

    // limit of zero reads as full size; grow, then release until the queue is full
    settle();
    set_reg(REG_SLOT_LIMIT, '0);
    set_reg(REG_BASE_SLOTS, cnt_t'(SLOT_CAP));
    send_op(KIND_RESIZE, '0);
    send_op(KIND_RELEASE, id_t'(0));
    send_op(KIND_RELEASE, id_t'(3));

    settle();
    set_reg(REG_HALTED, cnt_t'(1));
    send_op(KIND_ACQUIRE, '0);
    settle();
    set_reg(REG_HALTED, cnt_t'(0));
    set_reg(REG_BASE_SLOTS, cnt_t'(2));
    send_op(KIND_ACQUIRE, '0);
    send_op(KIND_SHRINK, '0);
    send_op(KIND_RELEASE, id_t'(2));
    send_op(KIND_SHRINK, '0);
    send_op(KIND_RESIZE, '0);

    // oversized limit saturates; base above provisioned makes shrink a no-op
    settle();
    set_reg(REG_SLOT_LIMIT, '1);
    set_reg(REG_BASE_SLOTS, cnt_t'(300));
    send_op(KIND_RESIZE, '0);
    send_op(KIND_ACQUIRE, '0);
    send_op(KIND_SHRINK, '0);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      settle();
      shuffle_config();
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        6, 7: begin
          // grow, then drop back to a smaller base
          send_op(KIND_RESIZE, id_t'($urandom));
          mixed_traffic($urandom_range(0, 10));
          settle();
          set_reg(REG_BASE_SLOTS, cnt_t'($urandom_range(1, id_span)));
          send_op(KIND_SHRINK, id_t'($urandom));
          mixed_traffic($urandom_range(5, 15));
          send_op(KIND_SHRINK, id_t'($urandom));
        end
        8: begin
          repeat ($urandom_range(1, 6)) send_op(KIND_ACQUIRE, id_t'($urandom));
          repeat ($urandom_range(10, 60)) send_op(KIND_RELEASE, release_id());
          send_op(KIND_SHRINK, id_t'($urandom));
        end
        9: begin
          // flood with duplicates so the queue fills, then grow into it
          repeat ($urandom_range(20, 270)) send_op(KIND_RELEASE, release_id());
          send_op(KIND_RESIZE, id_t'($urandom));
        end
        default: begin
          mixed_traffic($urandom_range(8, 30));
        end
      endcase
    end

    settle();
    if (fail_count == 0 && answers_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bsfl_pkg.sv
hdl/bsfl_cfg.sv
hdl/bsfl_presence.sv
hdl/bounded_slot_free_list_top.sv
bench/bsfl_slot_monitor.sv
bench/tb_bounded_slot_free_list_top.sv
